### rtl/nsf_pkg.sv
package nsf_pkg;

    // map geometry, fixed by the field widths of the command word
    localparam int MAP_COLUMNS    = 32;
    localparam int MAP_ROWS       = 32;
    localparam int MAP_SIZE       = MAP_COLUMNS * MAP_ROWS;
    localparam int COL_W          = $clog2(MAP_COLUMNS);
    localparam int ROW_W          = $clog2(MAP_ROWS);
    localparam int SIZE_W         = 6;
    localparam int INDEX_W        = $clog2(MAP_SIZE);
    localparam int VALUE_W        = 16;
    localparam int PATTERN_DEPTH  = 16;
    localparam int PATTERN_SEL_W  = $clog2(PATTERN_DEPTH);
    localparam int CFG_DATA_W     = 64;
    localparam int CFG_INDEX_W    = 3;
    localparam int WORDS_PER_REG  = CFG_DATA_W / VALUE_W;
    localparam int PATTERN_REGS   = PATTERN_DEPTH / WORDS_PER_REG;

    localparam logic [SIZE_W-1:0] MIN_SIZE   = SIZE_W'(2);
    localparam logic [SIZE_W-1:0] MAX_WIDTH  = SIZE_W'(MAP_COLUMNS);
    localparam logic [SIZE_W-1:0] MAX_HEIGHT = SIZE_W'(MAP_ROWS);

    // command actions
    localparam logic ACTION_BEGIN = 1'b0;
    localparam logic ACTION_TICK  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_TILE_BASE    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WORDS_LOW    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WORDS_SECOND = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WORDS_THIRD  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_WORDS_HIGH   = 3'd4;

    typedef struct packed {
        logic              action;
        logic [COL_W-1:0]  left_column;
        logic [ROW_W-1:0]  top_row;
        logic [SIZE_W-1:0] frame_width;
        logic [SIZE_W-1:0] frame_height;
    } cmd_word_t;

    typedef struct packed {
        logic [INDEX_W-1:0] map_index;
        logic [VALUE_W-1:0] tile_value;
        logic               last_tile;
    } tile_word_t;

    typedef struct packed {
        logic              busy;
        logic [COL_W-1:0]  frame_left;
        logic [ROW_W-1:0]  frame_top;
        logic [SIZE_W-1:0] width_held;
        logic [SIZE_W-1:0] height_held;
        logic [COL_W-1:0]  cursor_column;
        logic [ROW_W-1:0]  cursor_row;
    } frame_state_t;

    typedef logic [PATTERN_DEPTH-1:0][VALUE_W-1:0] pattern_words_t;

endpackage

### rtl/nsf_cfg_regs.sv
module nsf_cfg_regs
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [nsf_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [nsf_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic [nsf_pkg::VALUE_W-1:0]         tile_base,
    output nsf_pkg::pattern_words_t             pattern_words
);

    logic [nsf_pkg::VALUE_W-1:0]                                  base_reg;
    logic [nsf_pkg::PATTERN_REGS-1:0][nsf_pkg::CFG_DATA_W-1:0]    words_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= '0;
            words_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                nsf_pkg::REG_TILE_BASE:    base_reg     <= cfg_data[nsf_pkg::VALUE_W-1:0];
                nsf_pkg::REG_WORDS_LOW:    words_reg[0] <= cfg_data;
                nsf_pkg::REG_WORDS_SECOND: words_reg[1] <= cfg_data;
                nsf_pkg::REG_WORDS_THIRD:  words_reg[2] <= cfg_data;
                nsf_pkg::REG_WORDS_HIGH:   words_reg[3] <= cfg_data;
                default:                   ;
            endcase
        end
    end

    assign tile_base     = base_reg;
    assign pattern_words = nsf_pkg::pattern_words_t'(words_reg);

endmodule

### rtl/nsf_cursor.sv
module nsf_cursor
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  nsf_pkg::cmd_word_t     cmd,
    output nsf_pkg::frame_state_t  state
);

    nsf_pkg::frame_state_t state_reg;
    nsf_pkg::frame_state_t state_next;

    logic                      col_end;
    logic                      row_end;
    logic [nsf_pkg::SIZE_W-1:0] width_clamped;
    logic [nsf_pkg::SIZE_W-1:0] height_clamped;

    assign col_end = ({1'b0, state_reg.cursor_column} == state_reg.width_held - 1'b1);
    assign row_end = ({1'b0, state_reg.cursor_row} == state_reg.height_held - 1'b1);

    always_comb
    begin
        priority if (cmd.frame_width < nsf_pkg::MIN_SIZE)
            width_clamped = nsf_pkg::MIN_SIZE;
        else if (cmd.frame_width > nsf_pkg::MAX_WIDTH)
            width_clamped = nsf_pkg::MAX_WIDTH;
        else
            width_clamped = cmd.frame_width;

        priority if (cmd.frame_height < nsf_pkg::MIN_SIZE)
            height_clamped = nsf_pkg::MIN_SIZE;
        else if (cmd.frame_height > nsf_pkg::MAX_HEIGHT)
            height_clamped = nsf_pkg::MAX_HEIGHT;
        else
            height_clamped = cmd.frame_height;
    end

    always_comb
    begin
        state_next = state_reg;
        if (accept)
        begin
            if (cmd.action == nsf_pkg::ACTION_BEGIN)
            begin
                state_next.busy          = 1'b1;
                state_next.frame_left    = cmd.left_column;
                state_next.frame_top     = cmd.top_row;
                state_next.width_held    = width_clamped;
                state_next.height_held   = height_clamped;
                state_next.cursor_column = '0;
                state_next.cursor_row    = '0;
            end
            else if (state_reg.busy)
            begin
                priority if (col_end && row_end)
                begin
                    state_next.busy          = 1'b0;
                    state_next.cursor_column = '0;
                    state_next.cursor_row    = '0;
                end
                else if (col_end)
                begin
                    state_next.cursor_column = '0;
                    state_next.cursor_row    = state_reg.cursor_row + 1'b1;
                end
                else
                begin
                    state_next.cursor_column = state_reg.cursor_column + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else
            state_reg <= state_next;
    end

    assign state = state_reg;

endmodule

### rtl/nsf_tile_calc.sv
module nsf_tile_calc
(
    input  nsf_pkg::frame_state_t          state,
    input  logic [nsf_pkg::VALUE_W-1:0]    tile_base,
    input  nsf_pkg::pattern_words_t        pattern_words,
    output nsf_pkg::tile_word_t            tile
);

    // frame pattern entries
    localparam logic [3:0] ENT_TOP_LEFT      = 4'd0;
    localparam logic [3:0] ENT_TOP_INNER     = 4'd1;
    localparam logic [3:0] ENT_TOP           = 4'd2;
    localparam logic [3:0] ENT_TOP_RIGHT     = 4'd3;
    localparam logic [3:0] ENT_LEFT_INNER    = 4'd4;
    localparam logic [3:0] ENT_INNER_CORNER  = 4'd5;
    localparam logic [3:0] ENT_FILL_ODD_ROW  = 4'd6;
    localparam logic [3:0] ENT_RIGHT_ODD     = 4'd7;
    localparam logic [3:0] ENT_LEFT          = 4'd8;
    localparam logic [3:0] ENT_FILL_ODD_COL  = 4'd9;
    localparam logic [3:0] ENT_FILL_EVEN_COL = 4'd10;
    localparam logic [3:0] ENT_RIGHT_EVEN    = 4'd11;
    localparam logic [3:0] ENT_BOTTOM_LEFT   = 4'd12;
    localparam logic [3:0] ENT_BOTTOM_ODD    = 4'd13;
    localparam logic [3:0] ENT_BOTTOM_EVEN   = 4'd14;
    localparam logic [3:0] ENT_BOTTOM_RIGHT  = 4'd15;

    localparam int LIN_W = nsf_pkg::INDEX_W + 2;

    logic [nsf_pkg::SIZE_W-1:0]        c_ext;
    logic [nsf_pkg::SIZE_W-1:0]        r_ext;
    logic [nsf_pkg::SIZE_W-1:0]        cm;
    logic [nsf_pkg::SIZE_W-1:0]        rm;
    logic                              at_cm;
    logic                              at_rm;
    logic                              at_c0;
    logic                              at_r0;
    logic                              at_c1;
    logic                              at_r1;
    logic [nsf_pkg::PATTERN_SEL_W-1:0] entry;
    logic [nsf_pkg::SIZE_W-1:0]        map_col;
    logic [nsf_pkg::SIZE_W-1:0]        map_row;
    logic [LIN_W-1:0]                  linear;

    assign c_ext = {1'b0, state.cursor_column};
    assign r_ext = {1'b0, state.cursor_row};
    assign cm    = state.width_held - 1'b1;
    assign rm    = state.height_held - 1'b1;
    assign at_cm = (c_ext == cm);
    assign at_rm = (r_ext == rm);
    assign at_c0 = (state.cursor_column == '0);
    assign at_r0 = (state.cursor_row == '0);
    assign at_c1 = (c_ext == nsf_pkg::SIZE_W'(1));
    assign at_r1 = (r_ext == nsf_pkg::SIZE_W'(1));

    // first match wins: bottom and top-right corners, inner entries, top-left corner, then edges, then fill
    always_comb
    begin
        priority if (at_cm && at_rm)  entry = ENT_BOTTOM_RIGHT;
        else if (at_c0 && at_rm)      entry = ENT_BOTTOM_LEFT;
        else if (at_cm && at_r0)      entry = ENT_TOP_RIGHT;
        else if (at_c1 && at_r1)      entry = ENT_INNER_CORNER;
        else if (at_c0 && at_r1)      entry = ENT_LEFT_INNER;
        else if (at_c1 && at_r0)      entry = ENT_TOP_INNER;
        else if (at_c0 && at_r0)      entry = ENT_TOP_LEFT;
        else if (at_r0)               entry = ENT_TOP;
        else if (at_rm)
            entry = state.cursor_column[0] ? ENT_BOTTOM_ODD : ENT_BOTTOM_EVEN;
        else if (at_c0)               entry = ENT_LEFT;
        else if (at_cm)
            entry = state.cursor_row[0] ? ENT_RIGHT_ODD : ENT_RIGHT_EVEN;
        else if (state.cursor_row[0]) entry = ENT_FILL_ODD_ROW;
        else
            entry = state.cursor_column[0] ? ENT_FILL_ODD_COL : ENT_FILL_EVEN_COL;
    end

    // linear map index wraps modulo the map size (a power of two); a column overflow runs into the next row
    assign map_col = {1'b0, state.frame_left} + c_ext;
    assign map_row = {1'b0, state.frame_top} + r_ext;
    assign linear  = LIN_W'(map_col) + LIN_W'(map_row) * LIN_W'(nsf_pkg::MAP_COLUMNS);

    assign tile.map_index  = linear[nsf_pkg::INDEX_W-1:0];
    assign tile.tile_value = pattern_words[entry] + tile_base;
    assign tile.last_tile  = at_cm && at_rm;

endmodule

### rtl/nine_slice_tile_frame_fill_core.sv
// channel  direction  word         handshake
// cmd      in         cmd_word     cmd_valid / cmd_stall
// tile     out        tile_word    tile_valid / tile_stall
// cfg      in         cfg_data     cfg_wr_en, cfg_index (no read-back)
//
// one command word per cycle while cmd_stall is low; a tick yields its tile word in the next cycle
// the cursor registers feed one pass of select/add logic into the tile register
// cmd_stall rises only while a tile word sits in the output register and is stalled
// rst_n clears config, frame state and the output valid; no clearing pass
module nine_slice_tile_frame_fill_core
(
    input  logic                              clk,
    input  logic                              rst_n,

    // command side
    input  logic                              cmd_valid,
    output logic                              cmd_stall,
    input  nsf_pkg::cmd_word_t                cmd_word,

    // tile write side
    output logic                              tile_valid,
    input  logic                              tile_stall,
    output nsf_pkg::tile_word_t               tile_word,

    // configuration writes
    input  logic                              cfg_wr_en,
    input  logic [nsf_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [nsf_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic                             cmd_accept;
    logic                             emit;
    logic [nsf_pkg::VALUE_W-1:0]      tile_base;
    nsf_pkg::pattern_words_t          pattern_words;
    nsf_pkg::frame_state_t            frame_state;
    nsf_pkg::tile_word_t              tile_calc;

    logic                             tile_valid_reg;
    logic                             tile_valid_next;
    nsf_pkg::tile_word_t              tile_word_reg;

    // new word may enter whenever the output register is free or draining
    assign cmd_stall  = tile_valid_reg & tile_stall;
    assign cmd_accept = cmd_valid & ~cmd_stall;

    // only a tick on a running frame produces a tile write
    assign emit = cmd_accept & (cmd_word.action == nsf_pkg::ACTION_TICK) & frame_state.busy;

    nsf_cfg_regs u_cfg_regs
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .tile_base     (tile_base),
        .pattern_words (pattern_words)
    );

    nsf_cursor u_cursor
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (cmd_accept),
        .cmd    (cmd_word),
        .state  (frame_state)
    );

    // entry select and base add for the cell under the cursor
    nsf_tile_calc u_tile_calc
    (
        .state         (frame_state),
        .tile_base     (tile_base),
        .pattern_words (pattern_words),
        .tile          (tile_calc)
    );

    always_comb
    begin
        if (emit)
            tile_valid_next = 1'b1;
        else if (tile_stall)
            tile_valid_next = tile_valid_reg;
        else
            tile_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tile_valid_reg <= 1'b0;
        else
            tile_valid_reg <= tile_valid_next;
    end

    // payload register, no reset needed
    always_ff @(posedge clk)
    begin
        if (emit)
            tile_word_reg <= tile_calc;
    end

    assign tile_valid = tile_valid_reg;
    assign tile_word  = tile_word_reg;

endmodule
